>>> design/cspg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cspg_pkg;

  localparam int RADIUS_W = 23;
  localparam int COUNT_W  = 16;
  localparam int POS_W    = 24;
  localparam int PROD_W   = RADIUS_W + COUNT_W;
  localparam int NUM_W    = PROD_W + 1;
  localparam int REM_W    = COUNT_W + 1;
  localparam int QUOT_W   = 32;
  localparam int PHASE_W  = 32;
  localparam int XY_W     = 34;
  localparam int ZC_W     = 33;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam int DEF_INDEX_BITS        = 16;
  localparam int DEF_CORDIC_ITERATIONS = 16;

  localparam logic [2:0] REG_RAD_FIRST   = 3'd0;
  localparam logic [2:0] REG_RAD_LAST    = 3'd1;
  localparam logic [2:0] REG_HEIGHT      = 3'd2;
  localparam logic [2:0] REG_POINT_COUNT = 3'd3;
  localparam logic [2:0] REG_TURN_COUNT  = 3'd4;

  localparam logic [RADIUS_W-1:0] RST_RAD_FIRST   = 23'd52429;
  localparam logic [RADIUS_W-1:0] RST_RAD_LAST    = 23'd10486;
  localparam logic [RADIUS_W-1:0] RST_HEIGHT      = 23'd104858;
  localparam logic [COUNT_W-1:0]  RST_POINT_COUNT = 16'd100;
  localparam logic [COUNT_W-1:0]  RST_TURN_COUNT  = 16'd768;

  localparam logic signed [XY_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [POS_W-1:0] POS_MAX = 24'sd8388607;
  localparam logic signed [POS_W-1:0] POS_MIN = -24'sd8388608;

  typedef struct packed {
    logic              in_range;
    logic [PROD_W-1:0] pr_start;
    logic [PROD_W-1:0] pr_end;
    logic [PROD_W-1:0] pr_z;
  } prod_t;

  typedef struct packed {
    logic                in_range;
    logic [PHASE_W-1:0]  phase;
    logic [RADIUS_W-1:0] radius;
    logic [RADIUS_W-1:0] zmag;
  } geom_t;

  typedef struct packed {
    logic                    in_range;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
  } point_t;

  // arctangent of 2^-k in units of 2^-32 turn
  function automatic logic [ZC_W-1:0] atan_turn(input logic [4:0] k);
    logic [ZC_W-1:0] v;
    unique case (k)
      5'd0:  v = 33'h020000000;
      5'd1:  v = 33'h012E4051E;
      5'd2:  v = 33'h009FB385B;
      5'd3:  v = 33'h0051111D4;
      5'd4:  v = 33'h0028B0D43;
      5'd5:  v = 33'h00145D7E1;
      5'd6:  v = 33'h000A2F61E;
      5'd7:  v = 33'h000517C55;
      5'd8:  v = 33'h00028BE53;
      5'd9:  v = 33'h000145F2F;
      5'd10: v = 33'h0000A2F98;
      5'd11: v = 33'h0000517CC;
      5'd12: v = 33'h000028BE6;
      5'd13: v = 33'h0000145F3;
      5'd14: v = 33'h00000A2FA;
      5'd15: v = 33'h00000517D;
      5'd16: v = 33'h0000028BE;
      5'd17: v = 33'h00000145F;
      5'd18: v = 33'h000000A30;
      5'd19: v = 33'h000000518;
      5'd20: v = 33'h00000028C;
      5'd21: v = 33'h000000146;
      5'd22: v = 33'h0000000A3;
      5'd23: v = 33'h000000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

>>> design/cspg_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module cspg_fifo #(
  parameter int W          = 8,
  parameter int DEPTH_LOG2 = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         rd,
  output logic [W-1:0]      rdata,
  output logic              empty
);
  localparam int DEPTH = 1 << DEPTH_LOG2;

  logic [W-1:0]          mem [DEPTH];
  logic [DEPTH_LOG2-1:0] wr_ptr;
  logic [DEPTH_LOG2-1:0] rd_ptr;
  logic [DEPTH_LOG2:0]   count;
  logic                  do_wr;
  logic                  do_rd;

  assign full  = (count == (DEPTH_LOG2 + 1)'(DEPTH));
  assign empty = (count == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> design/cspg_front.sv
`timescale 1ns / 1ps
`default_nettype none
module cspg_front #(
  parameter int INDEX_BITS = cspg_pkg::DEF_INDEX_BITS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   push,
  input  wire logic [INDEX_BITS-1:0]                  point_index,
  output logic                                        full,
  input  wire logic [cspg_pkg::RADIUS_W-1:0]          rad_first,
  input  wire logic [cspg_pkg::RADIUS_W-1:0]          rad_last,
  input  wire logic [cspg_pkg::RADIUS_W-1:0]          height,
  input  wire logic [cspg_pkg::COUNT_W-1:0]           point_count,
  input  wire logic [cspg_pkg::COUNT_W-1:0]           turn_count,
  input  wire logic                                   rd,
  output logic                                        empty,
  output cspg_pkg::prod_t                             item,
  output logic [INDEX_BITS+cspg_pkg::COUNT_W-1:0]     ang
);
  localparam int IXW   = (INDEX_BITS > cspg_pkg::COUNT_W) ? INDEX_BITS : cspg_pkg::COUNT_W;
  localparam int ANG_W = INDEX_BITS + cspg_pkg::COUNT_W;
  localparam int PW    = cspg_pkg::PROD_W;

  logic [IXW-1:0]                  i_ext;
  logic [IXW-1:0]                  n_ext;
  logic [cspg_pkg::COUNT_W-1:0]    i16;
  logic [cspg_pkg::COUNT_W-1:0]    rest;
  cspg_pkg::prod_t                 w_item;
  logic [ANG_W-1:0]                w_ang;

  assign i_ext = IXW'(point_index);
  assign n_ext = IXW'(point_count);
  assign i16   = i_ext[cspg_pkg::COUNT_W-1:0];
  assign rest  = point_count - i16;

  // classify and form the products; out-of-range requests are zeroed at the end
  always_comb begin
    w_item.in_range = (point_count != '0) && (i_ext < n_ext);
    w_item.pr_start = PW'(rad_first) * PW'(rest);
    w_item.pr_end   = PW'(rad_last) * PW'(i16);
    w_item.pr_z     = PW'(height) * PW'(i16);
    w_ang           = ANG_W'(point_index) * ANG_W'(turn_count);
  end

  cspg_fifo #(
    .W         ($bits(cspg_pkg::prod_t) + ANG_W),
    .DEPTH_LOG2(2)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (push),
    .wdata({w_item, w_ang}),
    .full (full),
    .rd   (rd),
    .rdata({item, ang}),
    .empty(empty)
  );

endmodule
`default_nettype wire

>>> design/cspg_divider.sv
`timescale 1ns / 1ps
`default_nettype none
module cspg_divider #(
  parameter int INDEX_BITS = cspg_pkg::DEF_INDEX_BITS
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   adv,
  input  wire logic                                   in_valid,
  input  wire cspg_pkg::prod_t                        in_item,
  input  wire logic [INDEX_BITS+cspg_pkg::COUNT_W-1:0] in_ang,
  input  wire logic [cspg_pkg::COUNT_W-1:0]           point_count,
  output logic                                        out_valid,
  output cspg_pkg::geom_t                             out_geom
);
  localparam int ANG_W = INDEX_BITS + cspg_pkg::COUNT_W;
  localparam int DW    = ANG_W + 24;
  localparam int STEPS = (DW > cspg_pkg::NUM_W) ? DW : cspg_pkg::NUM_W;
  localparam int RW    = cspg_pkg::REM_W;
  localparam int QW    = cspg_pkg::QUOT_W;
  localparam int LANES = 3;

  logic [cspg_pkg::NUM_W-1:0] half;
  logic                       v   [STEPS+1];
  logic                       ir  [STEPS+1];
  logic [STEPS-1:0]           dvd [STEPS+1][LANES];
  logic [RW-1:0]              rem [STEPS+1][LANES];
  logic [QW-1:0]              quo [STEPS+1][LANES];

  assign half = cspg_pkg::NUM_W'(point_count >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
    end
  end

  // lane 0: turn fraction, lane 1: radius, lane 2: descent
  always_ff @(posedge clk) begin
    if (adv) begin
      ir[0]     <= in_item.in_range;
      dvd[0][0] <= STEPS'({in_ang, 24'b0});
      dvd[0][1] <= STEPS'(cspg_pkg::NUM_W'(in_item.pr_start)
                          + cspg_pkg::NUM_W'(in_item.pr_end) + half);
      dvd[0][2] <= STEPS'(cspg_pkg::NUM_W'(in_item.pr_z) + half);
      for (int l = 0; l < LANES; l++) begin
        rem[0][l] <= '0;
        quo[0][l] <= '0;
      end
    end
  end

  for (genvar s = 0; s < STEPS; s++) begin : g_step
    always_ff @(posedge clk) begin
      if (rst) begin
        v[s+1] <= 1'b0;
      end else if (adv) begin
        v[s+1] <= v[s];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ir[s+1] <= ir[s];
      end
    end
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RW:0] trial;
      logic        ge;
      assign trial = {rem[s][l], dvd[s][l][STEPS-1-s]};
      assign ge    = (trial >= (RW + 1)'(point_count));
      always_ff @(posedge clk) begin
        if (adv) begin
          dvd[s+1][l] <= dvd[s][l];
          rem[s+1][l] <= ge ? RW'(trial - (RW + 1)'(point_count)) : RW'(trial);
          quo[s+1][l] <= {quo[s][l][QW-2:0], ge};
        end
      end
    end
  end

  assign out_valid         = v[STEPS];
  assign out_geom.in_range = ir[STEPS];
  assign out_geom.phase    = quo[STEPS][0];
  assign out_geom.radius   = quo[STEPS][1][cspg_pkg::RADIUS_W-1:0];
  assign out_geom.zmag     = quo[STEPS][2][cspg_pkg::RADIUS_W-1:0];

endmodule
`default_nettype wire

>>> design/cspg_cordic.sv
`timescale 1ns / 1ps
`default_nettype none
module cspg_cordic #(
  parameter int CORDIC_ITERATIONS = cspg_pkg::DEF_CORDIC_ITERATIONS
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            adv,
  input  wire logic            in_valid,
  input  wire cspg_pkg::geom_t in_geom,
  output logic                 out_valid,
  output cspg_pkg::point_t     out_point
);
  localparam int N    = CORDIC_ITERATIONS;
  localparam int XW   = cspg_pkg::XY_W;
  localparam int ZW   = cspg_pkg::ZC_W;
  localparam int RW   = cspg_pkg::RADIUS_W;
  localparam int PW   = cspg_pkg::POS_W;
  localparam int MW   = RW + 1 + XW;
  localparam int SW   = MW - 30;
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  logic                 v    [N+1];
  logic                 ir   [N+1];
  logic [1:0]           quad [N+1];
  logic [RW-1:0]        rad  [N+1];
  logic [RW-1:0]        zm   [N+1];
  logic signed [XW-1:0] x    [N+1];
  logic signed [XW-1:0] y    [N+1];
  logic signed [ZW-1:0] z    [N+1];

  logic                 q_v, m_v, o_v;
  logic                 q_ir, m_ir;
  logic [RW-1:0]        q_rad, q_zm, m_zm;
  logic signed [XW-1:0] q_c, q_s;
  logic signed [MW-1:0] m_px, m_py;
  logic signed [MW-1:0] t_x, t_y;
  logic signed [SW-1:0] s_x, s_y;
  logic signed [PW-1:0] sat_x, sat_y;
  cspg_pkg::point_t     o_pt;

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (adv) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ir[0]   <= in_geom.in_range;
      quad[0] <= in_geom.phase[31:30];
      rad[0]  <= in_geom.radius;
      zm[0]   <= in_geom.zmag;
      x[0]    <= cspg_pkg::CORDIC_GAIN;
      y[0]    <= '0;
      z[0]    <= $signed(ZW'(in_geom.phase[29:0]));
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_iter
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    logic signed [ZW-1:0] ang;
    assign dx  = x[k] >>> k;
    assign dy  = y[k] >>> k;
    assign ang = $signed(cspg_pkg::atan_turn(5'(k)));
    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (adv) begin
        v[k+1] <= v[k];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        ir[k+1]   <= ir[k];
        quad[k+1] <= quad[k];
        rad[k+1]  <= rad[k];
        zm[k+1]   <= zm[k];
        // rotate toward zero residual angle
        if (!z[k][ZW-1]) begin
          x[k+1] <= x[k] - dy;
          y[k+1] <= y[k] + dx;
          z[k+1] <= z[k] - ang;
        end else begin
          x[k+1] <= x[k] + dy;
          y[k+1] <= y[k] - dx;
          z[k+1] <= z[k] + ang;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_v <= 1'b0;
      m_v <= 1'b0;
      o_v <= 1'b0;
    end else if (adv) begin
      q_v <= v[N];
      m_v <= q_v;
      o_v <= m_v;
    end
  end

  // quadrant fold
  always_ff @(posedge clk) begin
    if (adv) begin
      q_ir  <= ir[N];
      q_rad <= rad[N];
      q_zm  <= zm[N];
      unique case (quad[N])
        QUAD_0: begin q_c <= x[N];  q_s <= y[N];  end
        QUAD_1: begin q_c <= -y[N]; q_s <= x[N];  end
        QUAD_2: begin q_c <= -x[N]; q_s <= -y[N]; end
        QUAD_3: begin q_c <= y[N];  q_s <= -x[N]; end
        default: begin q_c <= x[N]; q_s <= y[N];  end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_ir <= q_ir;
      m_zm <= q_zm;
      m_px <= MW'($signed({1'b0, q_rad})) * MW'(q_c);
      m_py <= MW'($signed({1'b0, q_rad})) * MW'(q_s);
    end
  end

  always_comb begin
    t_x = m_px + (MW'(1) <<< 29);
    t_y = m_py + (MW'(1) <<< 29);
    s_x = SW'(t_x >>> 30);
    s_y = SW'(t_y >>> 30);
    if (s_x > SW'(cspg_pkg::POS_MAX)) begin
      sat_x = cspg_pkg::POS_MAX;
    end else if (s_x < SW'(cspg_pkg::POS_MIN)) begin
      sat_x = cspg_pkg::POS_MIN;
    end else begin
      sat_x = PW'(s_x);
    end
    if (s_y > SW'(cspg_pkg::POS_MAX)) begin
      sat_y = cspg_pkg::POS_MAX;
    end else if (s_y < SW'(cspg_pkg::POS_MIN)) begin
      sat_y = cspg_pkg::POS_MIN;
    end else begin
      sat_y = PW'(s_y);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_pt.in_range <= m_ir;
      o_pt.pos_x    <= m_ir ? sat_x : '0;
      o_pt.pos_y    <= m_ir ? sat_y : '0;
      o_pt.pos_z    <= m_ir ? PW'(0) - PW'(m_zm) : '0;
    end
  end

  assign out_valid = o_v;
  assign out_point = o_pt;

endmodule
`default_nettype wire

>>> design/conical_spiral_point_generator.sv
// Conical spiral waypoint generator.
// Input queue side: drive point_index with push; the request is taken on a
// clock edge where push is high and full is low. Result queue side: while
// empty is low, pos_x, pos_y, pos_z and in_range show the oldest result; pop
// takes it. One result per request, in request order.
// Throughput is one request per cycle while the result queue has room. From
// the accepting edge a request passes through a short request queue, one
// restoring-division stage per dividend bit (INDEX_BITS + 40 of them), one
// CORDIC stage per iteration, then the quadrant fold, the radius multiply,
// rounding and the result queue.
// An index at or beyond point_count returns zeros with in_range low.
// When the result queue fills, the whole back pipeline holds; the request
// queue then fills and full rises. Nothing is dropped.
// Reset (rst, synchronous) empties both queues and the pipeline and loads
// the default registers. Registers sit on the APB port at 4*index and must
// be written only while no request is in flight.
`timescale 1ns / 1ps
`default_nettype none
module conical_spiral_point_generator #(
  parameter int INDEX_BITS        = cspg_pkg::DEF_INDEX_BITS,
  parameter int CORDIC_ITERATIONS = cspg_pkg::DEF_CORDIC_ITERATIONS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [cspg_pkg::ADDR_W-1:0]       paddr,
  input  wire logic [cspg_pkg::DATA_W-1:0]       pwdata,
  output logic [cspg_pkg::DATA_W-1:0]            prdata,
  output logic                                   pready,
  input  wire logic                              push,
  input  wire logic [INDEX_BITS-1:0]             point_index,
  output logic                                   full,
  input  wire logic                              pop,
  output logic                                   empty,
  output logic signed [cspg_pkg::POS_W-1:0]      pos_x,
  output logic signed [cspg_pkg::POS_W-1:0]      pos_y,
  output logic signed [cspg_pkg::POS_W-1:0]      pos_z,
  output logic                                   in_range
);
  localparam int ANG_W = INDEX_BITS + cspg_pkg::COUNT_W;

  logic [cspg_pkg::RADIUS_W-1:0] rad_first;
  logic [cspg_pkg::RADIUS_W-1:0] rad_last;
  logic [cspg_pkg::RADIUS_W-1:0] height;
  logic [cspg_pkg::COUNT_W-1:0]  point_count;
  logic [cspg_pkg::COUNT_W-1:0]  turn_count;
  logic [2:0]                    reg_sel;
  logic                          cfg_wr;

  logic                          q_empty;
  logic                          q_rd;
  cspg_pkg::prod_t               q_item;
  logic [ANG_W-1:0]              q_ang;
  logic                          adv;
  logic                          out_full;
  logic                          d_valid;
  cspg_pkg::geom_t               d_geom;
  logic                          c_valid;
  cspg_pkg::point_t              c_point;
  cspg_pkg::point_t              r_point;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rad_first   <= cspg_pkg::RST_RAD_FIRST;
      rad_last    <= cspg_pkg::RST_RAD_LAST;
      height      <= cspg_pkg::RST_HEIGHT;
      point_count <= cspg_pkg::RST_POINT_COUNT;
      turn_count  <= cspg_pkg::RST_TURN_COUNT;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        cspg_pkg::REG_RAD_FIRST:   rad_first   <= pwdata[cspg_pkg::RADIUS_W-1:0];
        cspg_pkg::REG_RAD_LAST:    rad_last    <= pwdata[cspg_pkg::RADIUS_W-1:0];
        cspg_pkg::REG_HEIGHT:      height      <= pwdata[cspg_pkg::RADIUS_W-1:0];
        cspg_pkg::REG_POINT_COUNT: point_count <= pwdata[cspg_pkg::COUNT_W-1:0];
        cspg_pkg::REG_TURN_COUNT:  turn_count  <= pwdata[cspg_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      cspg_pkg::REG_RAD_FIRST:   prdata = cspg_pkg::DATA_W'(rad_first);
      cspg_pkg::REG_RAD_LAST:    prdata = cspg_pkg::DATA_W'(rad_last);
      cspg_pkg::REG_HEIGHT:      prdata = cspg_pkg::DATA_W'(height);
      cspg_pkg::REG_POINT_COUNT: prdata = cspg_pkg::DATA_W'(point_count);
      cspg_pkg::REG_TURN_COUNT:  prdata = cspg_pkg::DATA_W'(turn_count);
      default:                   prdata = '0;
    endcase
  end

  // back pipeline moves as one while the result queue has room
  assign adv  = !out_full;
  assign q_rd = adv && !q_empty;

  cspg_front #(
    .INDEX_BITS(INDEX_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .point_index (point_index),
    .full        (full),
    .rad_first   (rad_first),
    .rad_last    (rad_last),
    .height      (height),
    .point_count (point_count),
    .turn_count  (turn_count),
    .rd          (q_rd),
    .empty       (q_empty),
    .item        (q_item),
    .ang         (q_ang)
  );

  cspg_divider #(
    .INDEX_BITS(INDEX_BITS)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .in_valid   (q_rd),
    .in_item    (q_item),
    .in_ang     (q_ang),
    .point_count(point_count),
    .out_valid  (d_valid),
    .out_geom   (d_geom)
  );

  cspg_cordic #(
    .CORDIC_ITERATIONS(CORDIC_ITERATIONS)
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (d_valid),
    .in_geom  (d_geom),
    .out_valid(c_valid),
    .out_point(c_point)
  );

  cspg_fifo #(
    .W         ($bits(cspg_pkg::point_t)),
    .DEPTH_LOG2(2)
  ) u_out (
    .clk  (clk),
    .rst  (rst),
    .wr   (c_valid && adv),
    .wdata(c_point),
    .full (out_full),
    .rd   (pop),
    .rdata(r_point),
    .empty(empty)
  );

  assign pos_x    = r_point.pos_x;
  assign pos_y    = r_point.pos_y;
  assign pos_z    = r_point.pos_z;
  assign in_range = r_point.in_range;

  a_zero_when_out_of_range: assert property (@(posedge clk) disable iff (rst)
    (!empty && !in_range) |-> (pos_x == '0 && pos_y == '0 && pos_z == '0))
    else $error("out-of-range result carries nonzero position");

  a_z_not_positive: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (pos_z[cspg_pkg::POS_W-1] || pos_z == '0))
    else $error("descent result is positive");

  a_range_needs_points: assert property (@(posedge clk) disable iff (rst)
    (!empty && in_range) |-> (point_count != '0))
    else $error("in-range result with zero point count");

  a_hold_on_full: assert property (@(posedge clk) disable iff (rst)
    out_full |-> !q_rd)
    else $error("request queue drained while pipeline held");

endmodule
`default_nettype wire

>>> tb/sv/tb_conical_spiral_point_generator.sv
`timescale 1ns / 1ps
module tb_conical_spiral_point_generator;

  localparam int IW = cspg_pkg::DEF_INDEX_BITS;
  localparam int PW = cspg_pkg::POS_W;
  localparam int AW = cspg_pkg::ADDR_W;
  localparam int DW = cspg_pkg::DATA_W;
  localparam int LATENCY = cspg_pkg::DEF_INDEX_BITS + cspg_pkg::DEF_CORDIC_ITERATIONS + 46;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  typedef struct {
    logic signed [PW-1:0] pos_x;
    logic signed [PW-1:0] pos_y;
    logic signed [PW-1:0] pos_z;
    logic                 in_range;
  } waypoint_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [AW-1:0] paddr = '0;
  logic [DW-1:0] pwdata = '0;
  logic [DW-1:0] prdata;
  logic pready;
  logic push = 1'b0;
  logic [IW-1:0] point_index = '0;
  logic full;
  logic pop = 1'b0;
  logic empty;
  logic signed [PW-1:0] pos_x, pos_y, pos_z;
  logic in_range;

  conical_spiral_point_generator i_dut (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .push, .point_index, .full, .pop, .empty, .pos_x, .pos_y, .pos_z, .in_range
  );

  always #5 clk = ~clk;

  // shadow copy of the spiral registers
  logic [cspg_pkg::RADIUS_W-1:0] cur_r_start = cspg_pkg::RST_RAD_FIRST;
  logic [cspg_pkg::RADIUS_W-1:0] cur_r_end   = cspg_pkg::RST_RAD_LAST;
  logic [cspg_pkg::RADIUS_W-1:0] cur_height  = cspg_pkg::RST_HEIGHT;
  logic [cspg_pkg::COUNT_W-1:0]  cur_count   = cspg_pkg::RST_POINT_COUNT;
  logic [cspg_pkg::COUNT_W-1:0]  cur_turns   = cspg_pkg::RST_TURN_COUNT;

  logic [IW-1:0] index_queue[$];
  waypoint_t waypoint_queue[$];
  int errors = 0;
  int cycles = 0;
  bit drive_idle = 1'b0, sink_idle = 1'b0;
  int hold_off = 0;
  bit hold_go = 1'b0;
  bit hold_done = 1'b0;

  localparam longint ATAN_TURNS[24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
    64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  function automatic longint sat_pos(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic waypoint_t spiral_point(logic [IW-1:0] idx);
    waypoint_t w;
    longint unsigned n, i, red, r, zmag;
    logic [31:0] phase;
    longint x, y, z, c, s, dx, dy;
    n = cur_count;
    i = idx;
    w = '{0, 0, 0, 1'b0};
    if (n == 0 || i >= n) return w;
    red = (i * cur_turns) % (n * 256);
    phase = 32'((red << 24) / n);
    r = (longint'(cur_r_start) * (n - i) + longint'(cur_r_end) * i + (n >> 1)) / n;
    zmag = (longint'(cur_height) * i + (n >> 1)) / n;
    x = 652032874;
    y = 0;
    z = phase[29:0];
    for (int k = 0; k < cspg_pkg::DEF_CORDIC_ITERATIONS && k < 24; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURNS[k];
      end else begin
        x += dx; y -= dy; z += ATAN_TURNS[k];
      end
    end
    case (phase[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
    w.pos_x = PW'(sat_pos((longint'(r) * c + (64'sd1 <<< 29)) >>> 30));
    w.pos_y = PW'(sat_pos((longint'(r) * s + (64'sd1 <<< 29)) >>> 30));
    w.pos_z = PW'(-longint'(zmag));
    w.in_range = 1'b1;
    return w;
  endfunction

  // driver: random gaps except in a gap-free window
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (push && !full) begin
        waypoint_queue.insert(waypoint_queue.size(), spiral_point(point_index));
        void'(index_queue.pop_front());
      end
      drive_idle = (cycles % 1000 >= 700) ? 1'b0 : ($urandom_range(99) < 25);
      if (index_queue.size() > 0 && !drive_idle) begin
        push <= 1'b1;
        point_index <= index_queue[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // pop hold-off counter
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_off <= 400;
      hold_done <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    waypoint_t e;
    if (!rst) begin
      if (pop && !empty) begin
        if (waypoint_queue.size() == 0) begin
          $error("result with no request pending");
          errors++;
        end else begin
          e = waypoint_queue.pop_front();
          if (pos_x !== e.pos_x) begin
            $error("pos_x expected %0d actual %0d", e.pos_x, pos_x); errors++;
          end
          if (pos_y !== e.pos_y) begin
            $error("pos_y expected %0d actual %0d", e.pos_y, pos_y); errors++;
          end
          if (pos_z !== e.pos_z) begin
            $error("pos_z expected %0d actual %0d", e.pos_z, pos_z); errors++;
          end
          if (in_range !== e.in_range) begin
            $error("in_range expected %0d actual %0d", e.in_range, in_range);
            errors++;
          end
        end
      end
      if (hold_off > 0) begin
        pop <= 1'b0;
      end else begin
        sink_idle = (cycles % 1000 >= 700) ? 1'b0 : ($urandom_range(99) < 25);
        pop <= !sink_idle;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] regnum, logic [DW-1:0] value);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= AW'({regnum, 2'b00}); pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (regnum)
      cspg_pkg::REG_RAD_FIRST:   cur_r_start = value[cspg_pkg::RADIUS_W-1:0];
      cspg_pkg::REG_RAD_LAST:    cur_r_end = value[cspg_pkg::RADIUS_W-1:0];
      cspg_pkg::REG_HEIGHT:      cur_height = value[cspg_pkg::RADIUS_W-1:0];
      cspg_pkg::REG_POINT_COUNT: cur_count = value[cspg_pkg::COUNT_W-1:0];
      cspg_pkg::REG_TURN_COUNT:  cur_turns = value[cspg_pkg::COUNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain_pipe();
    wait (index_queue.size() == 0 && !push && waypoint_queue.size() == 0);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic queue_indices(int count, bit in_bounds);
    for (int k = 0; k < count; k++) begin
      if (in_bounds && cur_count > 0 && $urandom_range(9) > 0)
        index_queue.insert(index_queue.size(), IW'($urandom_range(cur_count - 1)));
      else
        index_queue.insert(index_queue.size(), IW'($urandom_range(16'hFFFF)));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // default registers: ends of the range and beyond
    index_queue = '{16'd0, 16'd1, 16'd50, 16'd99, 16'd100, 16'hFFFF, 16'h8000};
    drain_pipe();
    reg_write(cspg_pkg::REG_RAD_FIRST, 32'hFFFF_FFFF);
    reg_write(cspg_pkg::REG_RAD_LAST, 32'd0);
    reg_write(cspg_pkg::REG_HEIGHT, 32'h007F_FFFF);
    reg_write(cspg_pkg::REG_POINT_COUNT, 32'd65535);
    reg_write(cspg_pkg::REG_TURN_COUNT, 32'd65535);
    index_queue = '{16'd0, 16'd1, 16'd16383, 16'd32767, 16'd65534, 16'hFFFF,
                    16'h5555, 16'hAAAA};
    drain_pipe();
    reg_write(cspg_pkg::REG_POINT_COUNT, 32'd0);
    reg_write(cspg_pkg::REG_TURN_COUNT, 32'd0);
    index_queue = '{16'd0, 16'd1, 16'hFFFF};
    drain_pipe();
    // unmapped address: no register changes
    reg_write(REG_UNMAPPED, 32'h1234_5678);
    reg_write(cspg_pkg::REG_POINT_COUNT, 32'd1);
    reg_write(cspg_pkg::REG_RAD_LAST, 32'h007F_FFFF);
    index_queue = '{16'd0, 16'd1};
    drain_pipe();
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(cspg_pkg::REG_RAD_FIRST, $urandom());
      reg_write(cspg_pkg::REG_RAD_LAST, $urandom());
      reg_write(cspg_pkg::REG_HEIGHT, $urandom());
      reg_write(cspg_pkg::REG_POINT_COUNT, ph == 5 ? 32'd65535 : $urandom_range(300, 1));
      reg_write(cspg_pkg::REG_TURN_COUNT, ph == 0 ? 32'd0 : $urandom());
      queue_indices(190, 1'b1);
      // long pop hold-off while requests keep coming
      if (ph == 2) hold_go = 1'b1;
      drain_pipe();
    end
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule
